@@ hdl/dsc_pkg.sv @@
// Shared types and constants for the detection-to-square-crop block.
// No dependencies; imported by detection_to_square_crop_rect.
package dsc_pkg;

  localparam int FracBitsDef = 8;
  localparam int DimBitsDef  = 14;

  localparam int CfgDataW   = 16;
  localparam int CfgIdxW    = 2;
  localparam int RelBits    = 16;
  localparam int MarginFrac = 12;
  localparam int OutW       = 17;
  localparam int MulBW      = 17;

  localparam int ImgWidthRst  = 640;
  localparam int ImgHeightRst = 480;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMG_W  = 2'd0,
    CFG_IMG_H  = 2'd1,
    CFG_MARGIN = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_REL_BOX = 2'd0,
    OP_PIX_BOX = 2'd1,
    OP_REL_KPT = 2'd2,
    OP_BAD_BOX = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] size_w;
    logic signed [23:0] size_h;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [OutW-1:0] center_x;
    logic [OutW-1:0] center_y;
    logic [OutW-1:0] side_x;
    logic [OutW-1:0] side_y;
    logic            format_error;
  } out_t;

endpackage

@@ hdl/detection_to_square_crop_rect.sv @@
// Detection to square crop rectangle: extents, squaring, margin, normalization.
// Depends on dsc_pkg (types, constants).
//
// One detection arrives as a box request followed by keypoint requests; busy is
// high while a request is in work and start is ignored then. A relative box
// passes its four coordinates in turn through the one shared multiplier (S_MUL,
// then S_CONV), a relative keypoint after a usable box its two; a pixel box or an
// unsupported box goes straight to S_UPD. A request with last set after a usable
// box then runs squaring, margin and the bit-serial divider that forms the four
// normalized outputs in turn; with no usable box S_FIN outputs a format error.
// The result shows on out_data for exactly one cycle with out_valid high; the
// receiver cannot stall it, so it must take it in that cycle.
module detection_to_square_crop_rect
  import dsc_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef,
  parameter int DIM_BITS  = DimBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  in_t                 in_data,
  output logic                out_valid,
  output out_t                out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  localparam int CW    = DIM_BITS + FRAC_BITS;
  localparam int GW    = CW + 3;
  localparam int MW    = (GW > 25) ? GW : 25;
  localparam int PW    = MW + MulBW;
  localparam int RSH   = RelBits - FRAC_BITS;
  localparam int NUMW  = CW + 17;
  localparam int CNTW  = $clog2(NUMW);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_MUL    = 16'h0002,
    S_CONV   = 16'h0004,
    S_UPD    = 16'h0008,
    S_FIN    = 16'h0010,
    S_SQ1    = 16'h0020,
    S_SQ2    = 16'h0040,
    S_SQ3    = 16'h0080,
    S_SQ4    = 16'h0100,
    S_MM     = 16'h0200,
    S_MG     = 16'h0400,
    S_MA     = 16'h0800,
    S_DLOAD  = 16'h1000,
    S_DIV    = 16'h2000,
    S_DSTORE = 16'h4000,
    S_OUT    = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  logic [DIM_BITS-1:0] img_w_r, img_h_r;
  logic [15:0]         margin_cfg_r;

  in_t                 in_r, in_nxt;
  logic [1:0]          k_r, k_nxt;
  logic [CW-1:0]       t_r [4];
  logic [CW-1:0]       t_nxt [4];
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic [CW-1:0]       minx_r, miny_r, maxx_r, maxy_r;
  logic [CW-1:0]       minx_nxt, miny_nxt, maxx_nxt, maxy_nxt;
  logic                box_seen_r, box_seen_nxt;
  logic signed [GW-1:0] xa_r, xb_r, ya_r, yb_r, xa_nxt, xb_nxt, ya_nxt, yb_nxt;
  logic                wide_r, wide_nxt;
  logic signed [GW-1:0] diff_r, diff_nxt, afford_r, afford_nxt, margin_r, margin_nxt;
  logic [1:0]          j_r, j_nxt;
  logic [NUMW-1:0]     num_r, num_nxt;
  logic [CW-1:0]       rem_r, rem_nxt, den_r, den_nxt;
  logic [OutW-1:0]     q_r, q_nxt;
  logic [CNTW-1:0]     cnt_r, cnt_nxt;
  logic [OutW-1:0]     res_r [4];
  logic [OutW-1:0]     res_nxt [4];
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;

  logic [DIM_BITS-1:0]  wpx, hpx;
  logic [CW-1:0]        w_fix, h_fix;
  logic signed [GW-1:0] wg, hg;
  logic signed [24:0]   rv [4];
  logic [CW-1:0]        pix [4];
  logic signed [MW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;

  function automatic logic [CW-1:0] clampf(input logic signed [PW-1:0] v,
                                           input logic [CW-1:0] lim);
    logic signed [PW-1:0] lim_s;
    lim_s = $signed(PW'({1'b0, lim}));
    if (v < 0) return '0;
    else if (v > lim_s) return lim;
    else return v[CW-1:0];
  endfunction

  assign wpx   = (img_w_r == '0) ? DIM_BITS'(1) : img_w_r;
  assign hpx   = (img_h_r == '0) ? DIM_BITS'(1) : img_h_r;
  assign w_fix = CW'(wpx) << FRAC_BITS;
  assign h_fix = CW'(hpx) << FRAC_BITS;
  assign wg    = $signed(GW'(w_fix));
  assign hg    = $signed(GW'(h_fix));

  assign rv[0] = 25'(in_r.pos_x);
  assign rv[1] = 25'(in_r.pos_y);
  assign rv[2] = 25'(in_r.pos_x) + 25'(in_r.size_w);
  assign rv[3] = 25'(in_r.pos_y) + 25'(in_r.size_h);

  assign pix[0] = clampf(PW'(rv[0]) <<< FRAC_BITS, w_fix);
  assign pix[1] = clampf(PW'(rv[1]) <<< FRAC_BITS, h_fix);
  assign pix[2] = clampf(PW'(rv[2]) <<< FRAC_BITS, w_fix);
  assign pix[3] = clampf(PW'(rv[3]) <<< FRAC_BITS, h_fix);

  // shared multiplier: coordinate scaling, then margin
  always_comb begin
    logic signed [GW-1:0] sd;
    sd = ((xb_r - xa_r) < (yb_r - ya_r)) ? (xb_r - xa_r) : (yb_r - ya_r);
    if (state_r == S_MM) begin
      mul_a = MW'(sd);
      mul_b = $signed({1'b0, margin_cfg_r});
    end else begin
      mul_a = MW'(rv[k_r]);
      mul_b = $signed(MulBW'(k_r[0] ? hpx : wpx));
    end
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    logic [CW-1:0] x0, y0, x1, y1;
    logic signed [GW-1:0] wd, ht, smin, smax, slim, lmin, lmax, sub, add, sd;
    logic signed [PW-1:0] m;
    logic [CW:0] r2;
    state_nxt     = state_r;
    in_nxt        = in_r;
    k_nxt         = k_r;
    t_nxt         = t_r;
    prod_nxt      = prod_r;
    minx_nxt      = minx_r;
    miny_nxt      = miny_r;
    maxx_nxt      = maxx_r;
    maxy_nxt      = maxy_r;
    box_seen_nxt  = box_seen_r;
    xa_nxt        = xa_r;
    xb_nxt        = xb_r;
    ya_nxt        = ya_r;
    yb_nxt        = yb_r;
    wide_nxt      = wide_r;
    diff_nxt      = diff_r;
    afford_nxt    = afford_r;
    margin_nxt    = margin_r;
    j_nxt         = j_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    x0 = '0; y0 = '0; x1 = '0; y1 = '0;
    wd = xb_r - xa_r;
    ht = yb_r - ya_r;
    sd = (wd < ht) ? wd : ht;
    lmin = wide_r ? xa_r : ya_r;
    lmax = wide_r ? xb_r : yb_r;
    smin = wide_r ? ya_r : xa_r;
    smax = wide_r ? yb_r : xb_r;
    slim = wide_r ? hg : wg;
    sub = '0; add = '0;
    m = '0;
    r2 = {rem_r, num_r[NUMW-1]};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          in_nxt = in_data;
          k_nxt  = '0;
          if (in_data.op == OP_REL_BOX ||
              (in_data.op == OP_REL_KPT && box_seen_r)) begin
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_UPD;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_CONV;
      end
      S_CONV: begin
        t_nxt[k_r] = clampf(prod_r >>> RSH, k_r[0] ? h_fix : w_fix);
        if (k_r == ((in_r.op == OP_REL_BOX) ? 2'd3 : 2'd1)) begin
          state_nxt = S_UPD;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_UPD: begin
        if (in_r.op == OP_REL_BOX) begin
          x0 = t_r[0]; y0 = t_r[1]; x1 = t_r[2]; y1 = t_r[3];
        end else begin
          x0 = pix[0]; y0 = pix[1]; x1 = pix[2]; y1 = pix[3];
        end
        case (in_r.op) inside
          OP_REL_BOX, OP_PIX_BOX: begin
            minx_nxt = (x0 < x1) ? x0 : x1;
            maxx_nxt = (x0 > x1) ? x0 : x1;
            miny_nxt = (y0 < y1) ? y0 : y1;
            maxy_nxt = (y0 > y1) ? y0 : y1;
            box_seen_nxt = 1'b1;
          end
          OP_BAD_BOX: begin
            minx_nxt = '0; miny_nxt = '0; maxx_nxt = '0; maxy_nxt = '0;
            box_seen_nxt = 1'b0;
          end
          default: begin
            if (box_seen_r) begin
              if (t_r[0] < minx_r) minx_nxt = t_r[0];
              if (t_r[0] > maxx_r) maxx_nxt = t_r[0];
              if (t_r[1] < miny_r) miny_nxt = t_r[1];
              if (t_r[1] > maxy_r) maxy_nxt = t_r[1];
            end
          end
        endcase
        state_nxt = in_r.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (!box_seen_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.format_error = 1'b1;
          minx_nxt = '0; miny_nxt = '0; maxx_nxt = '0; maxy_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          xa_nxt = $signed(GW'(minx_r));
          xb_nxt = $signed(GW'(maxx_r));
          ya_nxt = $signed(GW'(miny_r));
          yb_nxt = $signed(GW'(maxy_r));
          state_nxt = S_SQ1;
        end
      end
      S_SQ1: begin
        wide_nxt   = wd > ht;
        diff_nxt   = (wd > ht) ? (wd - ht) : (ht - wd);
        afford_nxt = (wd > ht) ? (ya_r + hg - yb_r) : (xa_r + wg - xb_r);
        state_nxt  = S_SQ2;
      end
      S_SQ2: begin
        // grow the short side as far as the image allows, shrink the long one by the rest
        if (afford_r < diff_r) begin
          sub = diff_r - afford_r;
          add = afford_r;
        end else begin
          add = diff_r;
        end
        lmin = lmin + (sub >>> 1);
        lmax = lmax - (sub - (sub >>> 1));
        smin = smin - (add >>> 1);
        smax = smax + (add - (add >>> 1));
        if (wide_r) begin
          xa_nxt = lmin; xb_nxt = lmax; ya_nxt = smin; yb_nxt = smax;
        end else begin
          ya_nxt = lmin; yb_nxt = lmax; xa_nxt = smin; xb_nxt = smax;
        end
        state_nxt = S_SQ3;
      end
      S_SQ3: begin
        if (smin < 0) begin
          if (wide_r) begin
            yb_nxt = smax - smin; ya_nxt = '0;
          end else begin
            xb_nxt = smax - smin; xa_nxt = '0;
          end
        end
        state_nxt = S_SQ4;
      end
      S_SQ4: begin
        if (smax > slim) begin
          if (wide_r) begin
            ya_nxt = smin - (smax - slim); yb_nxt = slim;
          end else begin
            xa_nxt = smin - (smax - slim); xb_nxt = slim;
          end
        end
        state_nxt = S_MM;
      end
      S_MM: begin
        prod_nxt  = mul_p;
        state_nxt = S_MG;
      end
      S_MG: begin
        // limit the margin by the room to every image edge
        m = prod_r >>> MarginFrac;
        if (PW'(xa_r) < m) m = PW'(xa_r);
        if (PW'(ya_r) < m) m = PW'(ya_r);
        if (PW'(wg - xb_r) < m) m = PW'(wg - xb_r);
        if (PW'(hg - yb_r) < m) m = PW'(hg - yb_r);
        if (m < 0) m = '0;
        margin_nxt = GW'(m);
        state_nxt  = S_MA;
      end
      S_MA: begin
        xa_nxt = xa_r - margin_r;
        xb_nxt = xb_r + margin_r;
        ya_nxt = ya_r - margin_r;
        yb_nxt = yb_r + margin_r;
        j_nxt  = '0;
        state_nxt = S_DLOAD;
      end
      S_DLOAD: begin
        case (j_r)
          2'd0:    num_nxt = NUMW'(xa_r + xb_r) << (RelBits - 1);
          2'd1:    num_nxt = NUMW'(ya_r + yb_r) << (RelBits - 1);
          default: num_nxt = NUMW'(sd) << RelBits;
        endcase
        den_nxt   = j_r[0] ? h_fix : w_fix;
        rem_nxt   = '0;
        q_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // one quotient bit a cycle; upper bits fall off the 17-bit quotient
        if (r2 >= {1'b0, den_r}) begin
          rem_nxt = CW'(r2 - {1'b0, den_r});
          q_nxt   = {q_r[OutW-2:0], 1'b1};
        end else begin
          rem_nxt = r2[CW-1:0];
          q_nxt   = {q_r[OutW-2:0], 1'b0};
        end
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(NUMW - 1)) state_nxt = S_DSTORE;
      end
      S_DSTORE: begin
        res_nxt[j_r] = q_r;
        if (j_r == 2'd3) begin
          state_nxt = S_OUT;
        end else begin
          j_nxt     = j_r + 2'd1;
          state_nxt = S_DLOAD;
        end
      end
      S_OUT: begin
        out_valid_nxt         = 1'b1;
        out_data_nxt.center_x = res_r[0];
        out_data_nxt.center_y = res_r[1];
        out_data_nxt.side_x   = res_r[2];
        out_data_nxt.side_y   = res_r[3];
        out_data_nxt.format_error = 1'b0;
        minx_nxt = '0; miny_nxt = '0; maxx_nxt = '0; maxy_nxt = '0;
        box_seen_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      img_w_r      <= DIM_BITS'(ImgWidthRst);
      img_h_r      <= DIM_BITS'(ImgHeightRst);
      margin_cfg_r <= '0;
      minx_r       <= '0;
      miny_r       <= '0;
      maxx_r       <= '0;
      maxy_r       <= '0;
      box_seen_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      minx_r      <= minx_nxt;
      miny_r      <= miny_nxt;
      maxx_r      <= maxx_nxt;
      maxy_r      <= maxy_nxt;
      box_seen_r  <= box_seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IMG_W:  img_w_r      <= cfg_wdata[DIM_BITS-1:0];
          CFG_IMG_H:  img_h_r      <= cfg_wdata[DIM_BITS-1:0];
          CFG_MARGIN: margin_cfg_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    k_r        <= k_nxt;
    t_r        <= t_nxt;
    prod_r     <= prod_nxt;
    xa_r       <= xa_nxt;
    xb_r       <= xb_nxt;
    ya_r       <= ya_nxt;
    yb_r       <= yb_nxt;
    wide_r     <= wide_nxt;
    diff_r     <= diff_nxt;
    afford_r   <= afford_nxt;
    margin_r   <= margin_nxt;
    j_r        <= j_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
